>>> src/lfbp_pkg.sv
// lfbp_pkg: shared types and constants for the lsb-first bit packer
// no dependencies; imported by every module of the block

package lfbp_pkg;

   // fixed field widths
   localparam int COUNT_W = 7;
   localparam int BYTE_W  = 8;
   localparam int VBITS_W = 4;

   // per-item control travelling from the front end to the back end
   typedef struct packed {
      logic [COUNT_W-1:0] bit_count;
      logic               flush;
   } lfbp_ctl_type;

endpackage

>>> src/lfbp_front.sv
// lfbp_front: input stage, saturates the bit count and masks unused chunk bits
// depends on lfbp_pkg

module lfbp_front
   import lfbp_pkg::*;
#(
   parameter int MAX_CHUNK_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [MAX_CHUNK_BITS-1:0] req_chunk_bits,
   input  logic [COUNT_W-1:0]        req_bit_count,
   input  logic                      req_flush,
   output logic                      push_valid,
   input  logic                      push_ready,
   output logic [MAX_CHUNK_BITS-1:0] push_chunk,
   output lfbp_ctl_type              push_ctl
);

   localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_CHUNK_BITS);

   logic                      valid_ff, valid_in;
   logic [MAX_CHUNK_BITS-1:0] chunk_ff, chunk_in;
   lfbp_ctl_type              ctl_ff, ctl_in;
   logic [COUNT_W-1:0]        sat_count;
   logic [MAX_CHUNK_BITS-1:0] keep_mask;
   logic                      take;

   // stage frees up when empty or when its entry moves into the queue
   assign req_ready = !valid_ff || push_ready;
   assign take      = req_valid && req_ready;

   // saturate the count and build the mask of bits that carry data
   always_comb begin
      sat_count = (req_bit_count > MaxCount) ? MaxCount : req_bit_count;
      for (int i = 0; i < MAX_CHUNK_BITS; i++) begin
         keep_mask[i] = (COUNT_W'(i) < sat_count);
      end
      chunk_in         = req_chunk_bits & keep_mask;
      ctl_in.bit_count = sat_count;
      ctl_in.flush     = req_flush;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (take) begin
         chunk_ff <= chunk_in;
         ctl_ff   <= ctl_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_chunk = chunk_ff;
   assign push_ctl   = ctl_ff;

endmodule

>>> src/lfbp_queue.sv
// lfbp_queue: two-entry queue between the front end and the back end
// depends on lfbp_pkg

module lfbp_queue
   import lfbp_pkg::*;
#(
   parameter int MAX_CHUNK_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_valid,
   output logic                      wr_ready,
   input  logic [MAX_CHUNK_BITS-1:0] wr_chunk,
   input  lfbp_ctl_type              wr_ctl,
   output logic                      rd_valid,
   input  logic                      rd_take,
   output logic [MAX_CHUNK_BITS-1:0] rd_chunk,
   output lfbp_ctl_type              rd_ctl
);

   logic [MAX_CHUNK_BITS-1:0] chunk_mem [2];
   lfbp_ctl_type              ctl_mem [2];
   logic                      wr_ptr_ff, wr_ptr_in;
   logic                      rd_ptr_ff, rd_ptr_in;
   logic [1:0]                fill_ff, fill_in;
   logic                      do_wr, do_rd;

   assign wr_ready = (fill_ff != 2'd2);
   assign rd_valid = (fill_ff != 2'd0);
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_take && rd_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         chunk_mem[wr_ptr_ff] <= wr_chunk;
         ctl_mem[wr_ptr_ff]   <= wr_ctl;
      end
   end

   assign rd_chunk = chunk_mem[rd_ptr_ff];
   assign rd_ctl   = ctl_mem[rd_ptr_ff];

endmodule

>>> src/lfbp_back.sv
// lfbp_back: merges chunks into pending bits, emits a byte a cycle unless stalled
// depends on lfbp_pkg

module lfbp_back
   import lfbp_pkg::*;
#(
   parameter int MAX_CHUNK_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_take,
   input  logic [MAX_CHUNK_BITS-1:0] q_chunk,
   input  lfbp_ctl_type              q_ctl,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [BYTE_W-1:0]         rsp_out_byte,
   output logic [VBITS_W-1:0]        rsp_valid_bits,
   output logic                      rsp_last
);

   localparam int ACC_W = MAX_CHUNK_BITS + BYTE_W - 1;
   localparam int CNT_W = $clog2(MAX_CHUNK_BITS + BYTE_W);
   localparam logic [CNT_W-1:0]   ByteCnt  = CNT_W'(BYTE_W);
   localparam logic [VBITS_W-1:0] FullBits = VBITS_W'(BYTE_W);

   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               flush_ff, flush_in;
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic [VBITS_W-1:0] out_vbits_ff, out_vbits_in;
   logic               out_last_ff, out_last_in;

   logic               full, need_emit, out_free, emit, emit_last;
   logic [CNT_W-1:0]   rem;
   logic [ACC_W-1:0]   base_acc;
   logic [CNT_W-1:0]   base_cnt;

   // what the current accumulator still owes
   assign full      = (cnt_ff >= ByteCnt);
   assign need_emit = full || (flush_ff && (cnt_ff != '0));
   assign out_free  = !out_valid_ff || rsp_ready;
   assign emit      = need_emit && out_free;
   assign rem       = cnt_ff - ByteCnt;
   assign emit_last = full ? ((rem < ByteCnt) && !(flush_ff && (rem != '0))) : 1'b1;

   // next chunk may merge in the same cycle as the final byte of the previous one
   assign q_take = q_valid && (!need_emit || (emit && emit_last));

   always_comb begin
      // state after this cycle's emission
      if (emit && full) begin
         base_acc = acc_ff >> BYTE_W;
         base_cnt = rem;
      end else if (emit) begin
         base_acc = '0;
         base_cnt = '0;
      end else begin
         base_acc = acc_ff;
         base_cnt = cnt_ff;
      end
      // merge a new chunk above the pending bits
      if (q_take) begin
         acc_in   = base_acc | (ACC_W'(q_chunk) << base_cnt[2:0]);
         cnt_in   = base_cnt + CNT_W'(q_ctl.bit_count);
         flush_in = q_ctl.flush;
      end else begin
         acc_in   = base_acc;
         cnt_in   = base_cnt;
         flush_in = flush_ff;
      end
      // output register
      out_byte_in  = acc_ff[BYTE_W-1:0];
      out_vbits_in = full ? FullBits : cnt_ff[VBITS_W-1:0];
      out_last_in  = emit_last;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // accumulator and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff  <= out_byte_in;
         out_vbits_ff <= out_vbits_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_valid_bits = out_vbits_ff;
   assign rsp_last       = out_last_ff;

endmodule

>>> src/lsb_first_bit_packer.sv
// lsb_first_bit_packer: top level, front end, queue and back end
// depends on lfbp_pkg, lfbp_front, lfbp_queue, lfbp_back
//
// Packs chunks of up to MAX_CHUNK_BITS bits into bytes, earliest bit in bit 0.
// Each chunk is registered and masked in the front end, waits in a two-entry
// queue, and is merged above the pending bits in the back end, which sends
// out one byte per cycle through its output register unless rsp_ready stalls
// it. A chunk occupies the back end for as long as it yields bytes, and the
// output stage sets the rate. A chunk that completes no byte and flushes
// nothing is merged without emitting. The final byte of each chunk carries
// last; a flush sends the partial byte with its valid bit count.

module lsb_first_bit_packer
   import lfbp_pkg::*;
#(
   parameter int MAX_CHUNK_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [MAX_CHUNK_BITS-1:0] req_chunk_bits,
   input  logic [COUNT_W-1:0]        req_bit_count,
   input  logic                      req_flush,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [BYTE_W-1:0]         rsp_out_byte,
   output logic [VBITS_W-1:0]        rsp_valid_bits,
   output logic                      rsp_last
);

   logic                      push_valid, push_ready;
   logic [MAX_CHUNK_BITS-1:0] push_chunk;
   lfbp_ctl_type              push_ctl;
   logic                      q_valid, q_take;
   logic [MAX_CHUNK_BITS-1:0] q_chunk;
   lfbp_ctl_type              q_ctl;

   // front end
   lfbp_front #(.MAX_CHUNK_BITS(MAX_CHUNK_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_chunk_bits (req_chunk_bits),
      .req_bit_count  (req_bit_count),
      .req_flush      (req_flush),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_chunk     (push_chunk),
      .push_ctl       (push_ctl)
   );

   // decoupling queue
   lfbp_queue #(.MAX_CHUNK_BITS(MAX_CHUNK_BITS)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_chunk (push_chunk),
      .wr_ctl   (push_ctl),
      .rd_valid (q_valid),
      .rd_take  (q_take),
      .rd_chunk (q_chunk),
      .rd_ctl   (q_ctl)
   );

   // back end
   lfbp_back #(.MAX_CHUNK_BITS(MAX_CHUNK_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_take         (q_take),
      .q_chunk        (q_chunk),
      .q_ctl          (q_ctl),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_valid_bits (rsp_valid_bits),
      .rsp_last       (rsp_last)
   );

endmodule
